// ===== hw/rtl/pfbr_pkg.sv =====
package pfbr_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned RGB_W = 24;
  localparam int unsigned STEP_W = 6;
  localparam int unsigned STEPS_W = 7;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FOG_COLOUR      = 3'd0,
    CFG_STEP_COUNT      = 3'd1,
    CFG_LAST_EQUALS_FOG = 3'd2,
    CFG_REMAP_ENABLE    = 3'd3,
    CFG_PALETTE_SIZE    = 3'd4
  } cfg_reg_e;

  localparam logic [RGB_W-1:0] FOG_COLOUR_RST = '0;
  localparam logic [STEPS_W-1:0] STEP_COUNT_RST = 7'd8;
  localparam logic [SIZE_W-1:0] PALETTE_SIZE_RST = 9'd256;

  typedef enum logic {
    ACTION_LOAD  = 1'b0,
    ACTION_QUERY = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    OUT_HELD  = 2'd0,
    OUT_BLEND = 2'd1,
    OUT_BEST  = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic               action;
    logic [RGB_W-1:0]   colour_in;
    logic [INDEX_W-1:0] entry_index;
    logic [STEP_W-1:0]  step_index;
  } in_item_t;

  typedef struct packed {
    logic [RGB_W-1:0]   fogged_colour;
    logic [INDEX_W-1:0] chosen_index;
    logic               step_invalid;
  } out_item_t;

  typedef struct packed {
    logic [RGB_W-1:0]   fog_colour;
    logic [STEPS_W-1:0] step_count;
    logic               last_equals_fog;
    logic               remap_enable;
    logic [SIZE_W-1:0]  palette_size;
  } cfg_t;

  typedef struct packed {
    logic     accept;
    logic     setup;
    logic     div_step;
    logic     scan_start;
    logic     out_load;
    out_sel_e out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic step_invalid;
    logic step_zero;
    logic remap_on;
    logic scan_done;
  } ctrl_status_t;

endpackage

// ===== hw/rtl/pfbr_dp.sv =====
module pfbr_dp #(
  parameter int unsigned PALETTE_DEPTH = pfbr_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfbr_pkg::cfg_t       cfg_i,
  input  pfbr_pkg::in_item_t   in_item_i,
  input  pfbr_pkg::ctrl_cmd_t  cmd_i,
  output pfbr_pkg::ctrl_status_t status_o,
  output pfbr_pkg::out_item_t  out_item_o
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned SW = (pfbr_pkg::SIZE_W > AW + 1) ? pfbr_pkg::SIZE_W : AW + 1;
  localparam int unsigned XW = (AW > pfbr_pkg::INDEX_W) ? AW : pfbr_pkg::INDEX_W;
  localparam int unsigned DW = 18;
  localparam int unsigned NW = 15;
  localparam logic [12:0] DepthC = 13'(PALETTE_DEPTH);
  localparam logic [SW-1:0] DepthS = SW'(PALETTE_DEPTH);

  function automatic logic [12:0] wrap_index(input logic [7:0] idx, input logic [12:0] depth);
    logic [13:0] r;
    r = '0;
    for (int k = 7; k >= 0; k--) begin
      r = {r[12:0], idx[k]};
      if (r >= {1'b0, depth}) begin
        r = r - {1'b0, depth};
      end
    end
    return r[12:0];
  endfunction

  function automatic logic [DW-1:0] dist_sq(input logic [23:0] a, input logic [23:0] b);
    logic [DW-1:0] total;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] df;
    total = '0;
    for (int c = 0; c < 3; c++) begin
      x = a[8*c +: 8];
      y = b[8*c +: 8];
      df = (x > y) ? x - y : y - x;
      total = total + DW'({8'd0, df} * {8'd0, df});
    end
    return total;
  endfunction

  function automatic logic [pfbr_pkg::INDEX_W-1:0] to_index(input logic [AW-1:0] a);
    logic [XW-1:0] t;
    t = XW'(a);
    return t[pfbr_pkg::INDEX_W-1:0];
  endfunction

  logic [23:0] mem [PALETTE_DEPTH];
  logic [23:0] rd_q;
  logic [12:0] in_wrap;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] rd_addr;
  logic mem_we;

  logic [AW-1:0] q_idx_q;
  logic [pfbr_pkg::STEP_W-1:0] q_step_q;

  logic [pfbr_pkg::STEPS_W-1:0] d_val;
  logic [pfbr_pkg::STEPS_W-1:0] d_minus_s;
  logic [pfbr_pkg::STEPS_W-1:0] s_ext;

  logic [2:0][6:0] rem_q;
  logic [2:0][7:0] low_q;
  logic [2:0][NW-1:0] num_c;
  logic [23:0] blended;

  logic [23:0] res_col_q;
  logic res_inv_q;

  logic [SW-1:0] size_ext;
  logic [SW-1:0] n_last_w;
  logic [AW-1:0] n_last;

  logic issuing_q;
  logic [AW-1:0] scan_addr_q;
  logic p1_v_q;
  logic [AW-1:0] p1_idx_q;
  logic p2_v_q;
  logic [AW-1:0] p2_idx_q;
  logic [DW-1:0] p2_dist_q;
  logic [23:0] p2_col_q;
  logic best_v_q;
  logic [DW-1:0] best_dist_q;
  logic [AW-1:0] best_idx_q;
  logic [23:0] best_col_q;

  pfbr_pkg::out_item_t out_q;
  pfbr_pkg::out_item_t out_d;

  assign in_wrap = wrap_index(in_item_i.entry_index, DepthC);
  assign in_addr = in_wrap[AW-1:0];
  assign rd_addr = cmd_i.accept ? in_addr : scan_addr_q;
  assign mem_we = cmd_i.accept && (in_item_i.action == pfbr_pkg::ACTION_LOAD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_addr] <= in_item_i.colour_in;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      q_idx_q <= in_addr;
      q_step_q <= in_item_i.step_index;
    end
  end

  assign s_ext = pfbr_pkg::STEPS_W'(q_step_q);
  assign d_val = cfg_i.last_equals_fog ? cfg_i.step_count - 7'd1 : cfg_i.step_count;
  assign d_minus_s = d_val - s_ext;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_c[c] = NW'(rd_q[8*c +: 8]) * NW'(d_minus_s)
               + NW'(cfg_i.fog_colour[8*c +: 8]) * NW'(s_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.setup) begin
        rem_q[c] <= num_c[c][14:8];
        low_q[c] <= num_c[c][7:0];
      end else if (cmd_i.div_step) begin
        if ({rem_q[c], low_q[c][7]} >= {1'b0, d_val}) begin
          rem_q[c] <= 7'({rem_q[c], low_q[c][7]} - {1'b0, d_val});
          low_q[c] <= {low_q[c][6:0], 1'b1};
        end else begin
          rem_q[c] <= {rem_q[c][5:0], low_q[c][7]};
          low_q[c] <= {low_q[c][6:0], 1'b0};
        end
      end
    end
  end

  assign blended = {low_q[2], low_q[1], low_q[0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      res_inv_q <= status_o.step_invalid;
      res_col_q <= status_o.step_invalid ? 24'd0 : rd_q;
    end
  end

  assign size_ext = SW'(cfg_i.palette_size);

  always_comb begin
    if (size_ext == '0) begin
      n_last_w = '0;
    end else if (size_ext > DepthS) begin
      n_last_w = DepthS - SW'(1);
    end else begin
      n_last_w = size_ext - SW'(1);
    end
  end

  assign n_last = n_last_w[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      scan_addr_q <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      best_v_q <= 1'b0;
    end else begin
      p1_v_q <= issuing_q;
      p2_v_q <= p1_v_q;
      if (cmd_i.scan_start) begin
        issuing_q <= 1'b1;
        scan_addr_q <= '0;
        best_v_q <= 1'b0;
      end else begin
        if (issuing_q) begin
          if (scan_addr_q == n_last) begin
            issuing_q <= 1'b0;
          end else begin
            scan_addr_q <= scan_addr_q + AW'(1);
          end
        end
        if (p2_v_q) begin
          best_v_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_idx_q <= scan_addr_q;
    p2_idx_q <= p1_idx_q;
    p2_col_q <= rd_q;
    p2_dist_q <= dist_sq(blended, rd_q);
    if (p2_v_q && (!best_v_q || (p2_dist_q <= best_dist_q))) begin
      best_dist_q <= p2_dist_q;
      best_idx_q <= p2_idx_q;
      best_col_q <= p2_col_q;
    end
  end

  always_comb begin
    status_o.is_query = (in_item_i.action == pfbr_pkg::ACTION_QUERY);
    status_o.step_invalid = (s_ext >= cfg_i.step_count);
    status_o.step_zero = (q_step_q == '0);
    status_o.remap_on = cfg_i.remap_enable;
    status_o.scan_done = !issuing_q && !p1_v_q && !p2_v_q;
  end

  always_comb begin
    out_d.chosen_index = to_index(q_idx_q);
    out_d.step_invalid = 1'b0;
    case (cmd_i.out_sel)
      pfbr_pkg::OUT_HELD: begin
        out_d.fogged_colour = res_col_q;
        out_d.step_invalid = res_inv_q;
      end
      pfbr_pkg::OUT_BLEND: begin
        out_d.fogged_colour = blended;
      end
      pfbr_pkg::OUT_BEST: begin
        out_d.fogged_colour = best_col_q;
        out_d.chosen_index = to_index(best_idx_q);
      end
      default: begin
        out_d.fogged_colour = res_col_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== hw/rtl/pfbr_ctrl.sv =====
module pfbr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  pfbr_pkg::ctrl_status_t status_i,
  output pfbr_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    SETUP,
    DIVIDE,
    SCAN,
    DONE
  } state_e;

  state_e state_q;
  logic [2:0] cnt_q;
  logic out_valid_q;
  pfbr_pkg::out_sel_e sel_q;

  always_comb begin
    in_ready_o = (state_q == IDLE);
    cmd_o.accept = in_valid_i && in_ready_o;
    cmd_o.setup = (state_q == SETUP);
    cmd_o.div_step = (state_q == DIVIDE);
    cmd_o.scan_start = (state_q == DIVIDE) && (cnt_q == 3'd7) && status_i.remap_on;
    cmd_o.out_load = (state_q == DONE) && (!out_valid_q || out_ready_i);
    cmd_o.out_sel = sel_q;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      sel_q <= pfbr_pkg::OUT_HELD;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (cmd_o.accept && status_i.is_query) begin
            state_q <= SETUP;
          end
        end
        SETUP: begin
          cnt_q <= '0;
          if (status_i.step_invalid || status_i.step_zero) begin
            sel_q <= pfbr_pkg::OUT_HELD;
            state_q <= DONE;
          end else begin
            state_q <= DIVIDE;
          end
        end
        DIVIDE: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            if (status_i.remap_on) begin
              state_q <= SCAN;
            end else begin
              sel_q <= pfbr_pkg::OUT_BLEND;
              state_q <= DONE;
            end
          end
        end
        SCAN: begin
          if (status_i.scan_done) begin
            sel_q <= pfbr_pkg::OUT_BEST;
            state_q <= DONE;
          end
        end
        DONE: begin
          if (cmd_o.out_load) begin
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_div_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SETUP && !status_i.step_invalid && !status_i.step_zero) |=>
    (state_q == DIVIDE && cnt_q == 3'd0))
    else $error("divide not started for a blended step");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.setup, cmd_o.div_step, cmd_o.out_load}))
    else $error("overlapping datapath commands");

  a_scan_needs_remap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_start |-> status_i.remap_on)
    else $error("scan started with remap off");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SCAN && status_i.scan_done) |=> (state_q == DONE && sel_q == pfbr_pkg::OUT_BEST))
    else $error("scan completion not taken");
`endif

endmodule

// ===== hw/rtl/palette_fog_blend_remap.sv =====
// Palette fog blend with optional nearest-entry remap.
// Input channel (in_valid_i/in_ready_o/in_item_i): a beat with action load
// writes colour_in into the palette entry entry_index and produces no result.
// A beat with action query blends the named entry toward the fog colour by
// step_index/d and produces exactly one beat on the output channel
// (out_valid_o/out_ready_i/out_item_o).
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i; the user
// must write it only while idle; the block itself does not enforce this. Load
// beats are taken every cycle while idle. A query goes through SETUP and DONE
// if the step is zero or invalid, SETUP, DIVIDE and DONE with a blend, and
// SETUP, DIVIDE, SCAN and DONE with remap, where the search reads one entry
// per cycle from the single palette read port. The result is loaded into the
// output register in DONE, and until then a query holds the input.
// The output register holds a finished result while the receiver stalls; a
// further query then waits in its last state until that beat is taken.
// Reset returns the config registers to defaults and the controller to idle;
// palette contents are not cleared and must be loaded before use.
module palette_fog_blend_remap #(
  parameter int unsigned PALETTE_DEPTH = pfbr_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  pfbr_pkg::in_item_t                     in_item_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output pfbr_pkg::out_item_t                    out_item_o,
  input  logic                                   cfg_we_i,
  input  logic [pfbr_pkg::CFG_INDEX_W-1:0]       cfg_index_i,
  input  logic [pfbr_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  pfbr_pkg::cfg_t cfg_q;
  pfbr_pkg::ctrl_cmd_t cmd;
  pfbr_pkg::ctrl_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fog_colour <= pfbr_pkg::FOG_COLOUR_RST;
      cfg_q.step_count <= pfbr_pkg::STEP_COUNT_RST;
      cfg_q.last_equals_fog <= 1'b0;
      cfg_q.remap_enable <= 1'b0;
      cfg_q.palette_size <= pfbr_pkg::PALETTE_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pfbr_pkg::CFG_FOG_COLOUR: begin
          cfg_q.fog_colour <= cfg_data_i[pfbr_pkg::RGB_W-1:0];
        end
        pfbr_pkg::CFG_STEP_COUNT: begin
          cfg_q.step_count <= cfg_data_i[pfbr_pkg::STEPS_W-1:0];
        end
        pfbr_pkg::CFG_LAST_EQUALS_FOG: begin
          cfg_q.last_equals_fog <= cfg_data_i[0];
        end
        pfbr_pkg::CFG_REMAP_ENABLE: begin
          cfg_q.remap_enable <= cfg_data_i[0];
        end
        pfbr_pkg::CFG_PALETTE_SIZE: begin
          cfg_q.palette_size <= cfg_data_i[pfbr_pkg::SIZE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  pfbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pfbr_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule
